// ===== rtl/sit_pkg.sv =====
package sit_pkg;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned MAX_RECORDS = 128;
  localparam int unsigned INDEX_SLOTS = 256;
  localparam int unsigned ARENA_BYTES = 4096;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_LEN);
  localparam int unsigned REC_W  = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int unsigned SLOT_W = $clog2(INDEX_SLOTS);
  localparam int unsigned AR_W   = $clog2(ARENA_BYTES);
  localparam int unsigned USED_W = $clog2(ARENA_BYTES + 1);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] CMD_INTERN = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_ERR   = 2'd0,
    SEL_FOUND = 2'd1,
    SEL_ADDED = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic [1:0]  command;
    logic        has_byte;
    logic [7:0]  char_byte;
    logic        last;
    logic [31:0] lookup_id;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] result_id;
    logic        added;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
  } out_t;

  typedef struct packed {
    logic     take;
    logic     fin;
    logic     latch_get;
    logic     probe_rd;
    logic     probe_next;
    logic     rec_rd_slot;
    logic     rec_rd_get;
    logic     get_ld;
    logic     i_clr;
    logic     i_inc;
    logic     cmp_rd;
    logic     copy_rd;
    logic     copy_wr;
    logic     get_rd;
    logic     commit;
    logic     emit;
    res_sel_e sel;
    status_e  status;
  } ctl_t;

  typedef struct packed {
    logic too_long;
    logic len_zero;
    logic slot_valid;
    logic hash_eq;
    logic len_eq;
    logic byte_eq;
    logic i_last;
    logic probe_last;
    logic room_ok;
    logic get_ok;
  } sts_t;

endpackage

// ===== rtl/string_interning_table_unit.sv =====
// steps: a byte item is taken in idle; a string end gets a finish step, then per probed
//   slot a read and check, a record check on a hash hit, a read and check per compared
//   byte; a stored intern adds a copy read and write per byte and a commit; results show
//   the cycle after the decision; get: record read, length load, then one byte per cycle
// throughput: one item at a time, taken while busy is low; receiver cannot stall
// reset: index empty, no records, arena empty, id_base 0, staging cleared
module string_interning_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  sit_pkg::in_t  item_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  output logic          res_valid_o,
  output sit_pkg::out_t res_o
);
  import sit_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic busy;

  sit_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .item_i  (item_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  sit_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy_o = busy;

endmodule

// ===== rtl/sit_ram.sv =====
module sit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sit_datapath.sv =====
module sit_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sit_pkg::in_t   item_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  sit_pkg::ctl_t  ctl_i,
  output sit_pkg::sts_t  sts_o,
  output logic           res_valid_o,
  output sit_pkg::out_t  res_o
);
  import sit_pkg::*;

  logic [31:0]       id_base_q;
  logic [LEN_W-1:0]  stg_len_q;
  logic              too_long_q;
  logic [31:0]       hash_q;
  logic [31:0]       hash_mul;
  logic [LEN_W-1:0]  cur_len_q;
  logic [31:0]       cur_hash_q;
  logic [31:0]       fin_hash;
  logic [SLOT_W-1:0] pos_q;
  logic [SLOT_W-1:0] probe_q;
  logic [IDX_W-1:0]  i_q;
  logic [USED_W-1:0] used_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [INDEX_SLOTS-1:0] slot_vld_q;
  logic [REC_W-1:0]  gid_q;
  logic [31:0]       lid_q;
  logic              bpend_q;
  logic              blast_q;
  logic              res_valid_q;
  out_t              res_q;

  logic [7:0]        stg_rdata;
  logic [7:0]        ar_rdata;
  logic [AR_W+LEN_W-1:0] rec_rdata;
  logic [CNT_W+31:0] slot_rdata;
  logic [CNT_W-1:0]  slot_rec;
  logic [AR_W-1:0]   rec_off;
  logic [LEN_W-1:0]  rec_len;
  logic [REC_W-1:0]  rec_raddr;
  logic [AR_W-1:0]   ar_raddr;
  logic [AR_W-1:0]   ar_waddr;
  logic [32:0]       new_id;
  logic [31:0]       found_id;
  logic [31:0]       gdiff;
  logic [USED_W:0]   used_sum;

  assign hash_mul  = 32'((hash_q ^ {24'h0, item_i.char_byte}) * FNV_PRIME);
  assign fin_hash  = (hash_q == 32'h0) ? 32'h1 : hash_q;
  assign slot_rec  = slot_rdata[CNT_W+31:32];
  assign rec_off   = rec_rdata[AR_W+LEN_W-1:LEN_W];
  assign rec_len   = rec_rdata[LEN_W-1:0];
  assign rec_raddr = ctl_i.rec_rd_get ? gid_q : REC_W'(slot_rec - CNT_W'(1));
  assign ar_raddr  = AR_W'(rec_off + AR_W'(i_q));
  assign ar_waddr  = AR_W'(used_q + USED_W'(i_q));
  assign new_id    = {1'b0, id_base_q} + 33'(cnt_q) + 33'd1;
  assign found_id  = id_base_q + 32'(slot_rec);
  assign gdiff     = item_i.lookup_id - id_base_q - 32'd1;
  assign used_sum  = (USED_W+1)'(used_q) + (USED_W+1)'(cur_len_q);

  always_comb begin
    sts_o.too_long   = too_long_q;
    sts_o.len_zero   = (stg_len_q == '0);
    sts_o.slot_valid = slot_vld_q[pos_q];
    sts_o.hash_eq    = (slot_rdata[31:0] == cur_hash_q);
    sts_o.len_eq     = (rec_len == cur_len_q);
    sts_o.byte_eq    = (stg_rdata == ar_rdata);
    sts_o.i_last     = (LEN_W'(i_q) == cur_len_q - LEN_W'(1));
    sts_o.probe_last = (probe_q == SLOT_W'(INDEX_SLOTS - 1));
    sts_o.room_ok    = (cnt_q < CNT_W'(MAX_RECORDS))
                       && (used_sum <= (USED_W+1)'(ARENA_BYTES)) && !new_id[32];
    sts_o.get_ok     = (item_i.lookup_id > id_base_q) && (gdiff < 32'(cnt_q));
  end

  sit_ram #(.Width(8), .Depth(MAX_LEN)) u_stage (
    .clk_i   (clk_i),
    .we_i    (ctl_i.take && (stg_len_q < LEN_W'(MAX_LEN))),
    .waddr_i (stg_len_q[IDX_W-1:0]),
    .wdata_i (item_i.char_byte),
    .re_i    (ctl_i.cmp_rd || ctl_i.copy_rd),
    .raddr_i (i_q),
    .rdata_o (stg_rdata)
  );

  sit_ram #(.Width(8), .Depth(ARENA_BYTES)) u_arena (
    .clk_i   (clk_i),
    .we_i    (ctl_i.copy_wr),
    .waddr_i (ar_waddr),
    .wdata_i (stg_rdata),
    .re_i    (ctl_i.cmp_rd || ctl_i.get_rd),
    .raddr_i (ar_raddr),
    .rdata_o (ar_rdata)
  );

  sit_ram #(.Width(AR_W + LEN_W), .Depth(MAX_RECORDS)) u_rec (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit),
    .waddr_i (cnt_q[REC_W-1:0]),
    .wdata_i ({used_q[AR_W-1:0], cur_len_q}),
    .re_i    (ctl_i.rec_rd_slot || ctl_i.rec_rd_get),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  sit_ram #(.Width(CNT_W + 32), .Depth(INDEX_SLOTS)) u_slot (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit),
    .waddr_i (pos_q),
    .wdata_i ({CNT_W'(cnt_q + CNT_W'(1)), cur_hash_q}),
    .re_i    (ctl_i.probe_rd),
    .raddr_i (pos_q),
    .rdata_o (slot_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q   <= '0;
      stg_len_q   <= '0;
      too_long_q  <= 1'b0;
      hash_q      <= FNV_BASIS;
      used_q      <= '0;
      cnt_q       <= '0;
      slot_vld_q  <= '0;
      bpend_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        id_base_q <= cfg_wdata_i;
      end
      if (ctl_i.take) begin
        if (stg_len_q < LEN_W'(MAX_LEN)) begin
          stg_len_q <= stg_len_q + LEN_W'(1);
        end else begin
          too_long_q <= 1'b1;
        end
        hash_q <= hash_mul;
      end
      if (ctl_i.fin) begin
        stg_len_q  <= '0;
        too_long_q <= 1'b0;
        hash_q     <= FNV_BASIS;
      end
      if (ctl_i.commit) begin
        used_q            <= used_q + USED_W'(cur_len_q);
        cnt_q             <= cnt_q + CNT_W'(1);
        slot_vld_q[pos_q] <= 1'b1;
      end
      bpend_q     <= ctl_i.get_rd;
      res_valid_q <= bpend_q || ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      cur_len_q  <= stg_len_q;
      cur_hash_q <= fin_hash;
      pos_q      <= fin_hash[SLOT_W-1:0];
      probe_q    <= '0;
    end
    if (ctl_i.probe_next) begin
      pos_q   <= pos_q + SLOT_W'(1);
      probe_q <= probe_q + SLOT_W'(1);
    end
    if (ctl_i.latch_get) begin
      gid_q <= gdiff[REC_W-1:0];
      lid_q <= item_i.lookup_id;
    end
    if (ctl_i.get_ld) begin
      cur_len_q <= rec_len;
    end
    if (ctl_i.i_clr) begin
      i_q <= '0;
    end else if (ctl_i.i_inc) begin
      i_q <= i_q + IDX_W'(1);
    end
    if (ctl_i.get_rd) begin
      blast_q <= sts_o.i_last;
    end
    if (bpend_q) begin
      res_q.status    <= ST_OK;
      res_q.result_id <= lid_q;
      res_q.added     <= 1'b0;
      res_q.out_valid <= 1'b1;
      res_q.out_byte  <= ar_rdata;
      res_q.out_last  <= blast_q;
    end else if (ctl_i.emit) begin
      res_q.status    <= ctl_i.status;
      res_q.added     <= (ctl_i.sel == SEL_ADDED);
      res_q.out_valid <= 1'b0;
      res_q.out_byte  <= '0;
      res_q.out_last  <= 1'b1;
      case (ctl_i.sel)
        SEL_FOUND: res_q.result_id <= found_id;
        SEL_ADDED: res_q.result_id <= new_id[31:0];
        default:   res_q.result_id <= '0;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/sit_ctrl.sv =====
module sit_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sit_pkg::in_t   item_i,
  input  sit_pkg::sts_t  sts_i,
  output sit_pkg::ctl_t  ctl_o,
  output logic           busy_o
);
  import sit_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_PR_RD, S_PR_CHK, S_RC_CHK, S_CM_RD, S_CM_CHK,
    S_CP_RD, S_CP_WR, S_COMMIT, S_GET_REC, S_GET_LD, S_GET_ST, S_TAIL
  } state_e;

  state_e state_q, state_d;
  logic   find_q, find_d;

  always_comb begin
    ctl_o   = '0;
    ctl_o.sel    = SEL_ERR;
    ctl_o.status = ST_OK;
    state_d = state_q;
    find_d  = find_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (item_i.command == CMD_GET) begin
            if (sts_i.get_ok) begin
              ctl_o.latch_get = 1'b1;
              state_d = S_GET_REC;
            end else begin
              ctl_o.emit   = 1'b1;
              ctl_o.status = ST_NOT_FOUND;
            end
          end else if (item_i.command inside {CMD_INTERN, CMD_FIND}) begin
            ctl_o.take = item_i.has_byte;
            if (item_i.last) begin
              find_d  = (item_i.command == CMD_FIND);
              state_d = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        ctl_o.fin = 1'b1;
        if (sts_i.too_long) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = ST_TOO_LONG;
          state_d = S_IDLE;
        end else if (sts_i.len_zero) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = ST_EMPTY;
          state_d = S_IDLE;
        end else begin
          state_d = S_PR_RD;
        end
      end
      S_PR_RD: begin
        ctl_o.probe_rd = 1'b1;
        state_d = S_PR_CHK;
      end
      S_GET_REC: begin
        ctl_o.rec_rd_get = 1'b1;
        state_d = S_GET_LD;
      end
      S_GET_LD: begin
        ctl_o.get_ld = 1'b1;
        ctl_o.i_clr  = 1'b1;
        state_d = S_GET_ST;
      end
      S_GET_ST: begin
        ctl_o.get_rd = 1'b1;
        ctl_o.i_inc  = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_IDLE;
      end
      S_CM_RD: begin
        ctl_o.cmp_rd = 1'b1;
        state_d = S_CM_CHK;
      end
      S_CP_RD: begin
        ctl_o.copy_rd = 1'b1;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        ctl_o.copy_wr = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_COMMIT;
        end else begin
          ctl_o.i_inc = 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        ctl_o.emit   = 1'b1;
        ctl_o.sel    = SEL_ADDED;
        ctl_o.status = ST_OK;
        state_d = S_IDLE;
      end
      S_PR_CHK, S_RC_CHK, S_CM_CHK: begin
        if (state_q == S_PR_CHK && !sts_i.slot_valid) begin
          state_d = S_IDLE;
          if (find_q) begin
            ctl_o.emit   = 1'b1;
            ctl_o.status = ST_NOT_FOUND;
          end else if (sts_i.room_ok) begin
            ctl_o.i_clr = 1'b1;
            state_d = S_CP_RD;
          end else begin
            ctl_o.emit   = 1'b1;
            ctl_o.status = ST_NO_ROOM;
          end
        end else if (state_q == S_PR_CHK && sts_i.hash_eq) begin
          ctl_o.rec_rd_slot = 1'b1;
          state_d = S_RC_CHK;
        end else if (state_q == S_RC_CHK && sts_i.len_eq) begin
          ctl_o.i_clr = 1'b1;
          state_d = S_CM_RD;
        end else if (state_q == S_CM_CHK && sts_i.byte_eq) begin
          if (sts_i.i_last) begin
            ctl_o.emit   = 1'b1;
            ctl_o.sel    = SEL_FOUND;
            ctl_o.status = ST_OK;
            state_d = S_IDLE;
          end else begin
            ctl_o.i_inc = 1'b1;
            state_d = S_CM_RD;
          end
        end else if (sts_i.probe_last) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = find_q ? ST_NOT_FOUND : ST_NO_ROOM;
          state_d = S_IDLE;
        end else begin
          ctl_o.probe_next = 1'b1;
          state_d = S_PR_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      find_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      find_q  <= find_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sit_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_t         item_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        res_valid_o;
  out_t        res_o;

  string_interning_table_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table shadow
  logic [7:0]  stage_mem [MAX_LEN];
  int          stage_len;
  bit          stage_over;
  logic [31:0] fnv_acc;
  logic [7:0]  arena_mem [ARENA_BYTES];
  int          arena_fill;
  int          rec_off [MAX_RECORDS];
  int          rec_len [MAX_RECORDS];
  int          rec_cnt;
  int          slot_rec [INDEX_SLOTS];
  logic [31:0] slot_fnv [INDEX_SLOTS];
  logic [31:0] id_base;

  out_t        answer_q [$];
  int          fails;
  int          beats_checked;
  int          strings_added;

  function automatic void push_answer(status_e st, logic [31:0] id, bit add, bit v,
                                      logic [7:0] b, bit l);
    out_t o;
    o.status = st;
    o.result_id = id;
    o.added = add;
    o.out_valid = v;
    o.out_byte = b;
    o.out_last = l;
    answer_q.insert(answer_q.size(), o);
  endfunction

  function automatic bit stored_equal(int r, int n);
    if (rec_len[r] != n) return 0;
    for (int i = 0; i < n; i++)
      if (arena_mem[rec_off[r] + i] !== stage_mem[i]) return 0;
    return 1;
  endfunction

  function automatic void close_string(logic [1:0] cmd);
    int          n;
    bit          over;
    logic [31:0] h;
    int          pos;
    bit          free_seen;
    logic [32:0] new_id;
    n = stage_len;
    over = stage_over;
    h = fnv_acc;
    free_seen = 0;
    stage_len = 0;
    stage_over = 0;
    fnv_acc = FNV_BASIS;
    if (over) begin
      push_answer(ST_TOO_LONG, 0, 0, 0, 0, 1);
      return;
    end
    if (n == 0) begin
      push_answer(ST_EMPTY, 0, 0, 0, 0, 1);
      return;
    end
    if (h == 0) h = 1;
    pos = h % INDEX_SLOTS;
    for (int p = 0; p < INDEX_SLOTS; p++) begin
      if (slot_rec[pos] == 0) begin
        free_seen = 1;
        break;
      end
      if (slot_fnv[pos] == h && stored_equal(slot_rec[pos] - 1, n)) begin
        push_answer(ST_OK, id_base + slot_rec[pos], 0, 0, 0, 1);
        return;
      end
      pos = (pos + 1) % INDEX_SLOTS;
    end
    if (cmd != CMD_INTERN) begin
      push_answer(ST_NOT_FOUND, 0, 0, 0, 0, 1);
      return;
    end
    new_id = {1'b0, id_base} + rec_cnt + 1;
    if (!free_seen || rec_cnt >= MAX_RECORDS || arena_fill + n > ARENA_BYTES || new_id[32]) begin
      push_answer(ST_NO_ROOM, 0, 0, 0, 0, 1);
      return;
    end
    rec_off[rec_cnt] = arena_fill;
    rec_len[rec_cnt] = n;
    for (int i = 0; i < n; i++) arena_mem[arena_fill + i] = stage_mem[i];
    arena_fill += n;
    rec_cnt++;
    slot_rec[pos] = rec_cnt;
    slot_fnv[pos] = h;
    strings_added++;
    push_answer(ST_OK, new_id[31:0], 1, 0, 0, 1);
  endfunction

  function automatic void predict_table(in_t it);
    logic [31:0] rel;
    int          r;
    if (it.command == 2'd3) return;
    if (it.command == CMD_GET) begin
      rel = it.lookup_id - id_base - 32'd1;
      if (it.lookup_id <= id_base || rel >= rec_cnt) begin
        push_answer(ST_NOT_FOUND, 0, 0, 0, 0, 1);
        return;
      end
      r = rel;
      for (int i = 0; i < rec_len[r]; i++)
        push_answer(ST_OK, it.lookup_id, 0, 1, arena_mem[rec_off[r] + i], i == rec_len[r] - 1);
      return;
    end
    if (it.has_byte) begin
      if (stage_len < MAX_LEN) stage_mem[stage_len++] = it.char_byte;
      else stage_over = 1;
      fnv_acc = (fnv_acc ^ {24'd0, it.char_byte}) * FNV_PRIME;
    end
    if (it.last) close_string(it.command);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one beat in, waits for acceptance
  task automatic send_beat(in_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    predict_table(it);
  endtask

  task automatic send_request(logic [1:0] cmd, logic [7:0] txt [$], bit flip,
                              logic [31:0] lid);
    in_t it;
    it.lookup_id = $urandom;
    it.command = cmd;
    if (cmd == CMD_GET) begin
      it.has_byte = $urandom_range(0, 1);
      it.char_byte = $urandom;
      it.last = $urandom_range(0, 1);
      it.lookup_id = lid;
      send_beat(it);
    end else if (txt.size() == 0) begin
      it.has_byte = 1'b0;
      it.char_byte = $urandom;
      it.last = 1'b1;
      send_beat(it);
    end else begin
      for (int i = 0; i < txt.size(); i++) begin
        it.last = (i == txt.size() - 1);
        it.has_byte = 1'b1;
        it.char_byte = txt[i];
        it.lookup_id = $urandom;
        it.command = (flip && !it.last) ? (cmd ^ 2'd1) : cmd;
        send_beat(it);
      end
    end
  endtask

  task automatic send_noise();
    in_t         it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    if ($urandom_range(0, 1)) it.command = 2'd3;
    else begin
      it.command = $urandom_range(0, 1) ? CMD_FIND : CMD_INTERN;
      it.has_byte = 1'b0;
      it.last = 1'b0;
    end
    send_beat(it);
  endtask

  task automatic settle();
    int w;
    w = 0;
    start_i <= 1'b0;
    while (answer_q.size() != 0 && w < 200000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    id_base = v;
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 9) < 8) return id_base + $urandom_range(0, rec_cnt + 1);
    return $urandom;
  endfunction

  task automatic random_requests(int n_items, int alpha);
    logic [7:0]  txt [$];
    int          r;
    int          n;
    int          sent;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      txt.delete();
      if (r < 5) begin
        send_noise();
      end else if (r < 30) begin
        send_request(CMD_GET, txt, 0, pick_id());
        sent++;
      end else begin
        if ($urandom_range(0, 19) == 0) n = 0;
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(5, MAX_LEN + 4);
        else n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          txt.insert(txt.size(),
                     n > 4 ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h61 + alpha - 1)));
        send_request(r < 60 ? CMD_INTERN : CMD_FIND, txt, $urandom_range(0, 9) == 0, 0);
        sent += (n == 0) ? 1 : n;
      end
    end
  endtask

  typedef struct {
    logic [1:0]  cmd;
    string       txt;
    int          nb;
    bit          flip;
    logic [31:0] lid;
    bit          chk;
    status_e     st;
    logic [31:0] id;
  } dir_row_t;

  dir_row_t rows [] = '{
    '{CMD_FIND,   "a",   0,  0, 0,            1, ST_NOT_FOUND, 0},
    '{CMD_GET,    "",    0,  0, 1,            1, ST_NOT_FOUND, 0},
    '{CMD_INTERN, "",    0,  0, 0,            1, ST_EMPTY,     0},
    '{CMD_INTERN, "ab",  0,  0, 0,            1, ST_OK,        1},
    '{CMD_INTERN, "ab",  0,  0, 0,            1, ST_OK,        1},
    '{CMD_FIND,   "ab",  0,  0, 0,            1, ST_OK,        1},
    '{CMD_GET,    "",    0,  0, 1,            0, ST_OK,        0},
    '{CMD_GET,    "",    0,  0, 0,            1, ST_NOT_FOUND, 0},
    '{CMD_GET,    "",    0,  0, 32'hFFFFFFFF, 1, ST_NOT_FOUND, 0},
    '{CMD_INTERN, "",    2,  0, 0,            1, ST_OK,        2},
    '{CMD_INTERN, "",    65, 0, 0,            1, ST_TOO_LONG,  0},
    '{CMD_INTERN, "",    64, 0, 0,            1, ST_OK,        3},
    '{CMD_FIND,   "b",   0,  0, 0,            1, ST_NOT_FOUND, 0},
    '{2'd3,       "zz",  0,  0, 0,            0, ST_OK,        0},
    '{CMD_FIND,   "abc", 0,  1, 0,            1, ST_NOT_FOUND, 0},
    '{CMD_INTERN, "abc", 0,  1, 0,            1, ST_OK,        4},
    '{CMD_GET,    "",    0,  0, 4,            0, ST_OK,        0},
    '{CMD_GET,    "",    0,  0, 3,            0, ST_OK,        0}
  };

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $realtime, res_o);
        fails++;
      end else begin
        if (res_o !== answer_q[0]) begin
          $display("%0t: beat differs, expected %p, actual %p", $realtime, answer_q[0], res_o);
          fails++;
        end
        void'(answer_q.pop_front());
        beats_checked++;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("string_interning_table_unit: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] txt [$];
    int         w;
    fails = 0;
    beats_checked = 0;
    strings_added = 0;
    stage_len = 0;
    stage_over = 0;
    fnv_acc = FNV_BASIS;
    arena_fill = 0;
    rec_cnt = 0;
    id_base = 0;
    for (int i = 0; i < INDEX_SLOTS; i++) slot_rec[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[k]) begin
      txt.delete();
      if (rows[k].nb > 0)
        for (int i = 0; i < rows[k].nb; i++)
          txt.insert(txt.size(), i == 0 ? 8'h00 : 8'hFF ^ 8'(i));
      else
        for (int i = 0; i < rows[k].txt.len(); i++) txt.insert(txt.size(), rows[k].txt[i]);
      send_request(rows[k].cmd, txt, rows[k].flip, rows[k].lid);
      if (rows[k].chk) begin
        w = 0;
        while (answer_q.size() == 0 && w < 1000) begin
          @(posedge clk_i);
          w++;
        end
        if (answer_q.size() == 0 || answer_q[$].status != rows[k].st ||
            answer_q[$].result_id != rows[k].id) begin
          $display("%0t: row %0d expected %s id %0d, actual %p", $realtime, k,
                   rows[k].st.name(), rows[k].id, answer_q[$]);
          fails++;
        end
      end
    end
    write_base(32'h0);
    random_requests(20, 3);

    write_base($urandom);
    random_requests(20, 4);

    // near the top of the id space
    write_base(32'hFFFFFFFF - rec_cnt - 1);
    for (int k = 0; k < 3; k++) begin
      txt.delete();
      for (int i = 0; i < 6; i++) txt.insert(txt.size(), 8'($urandom));
      send_request(CMD_INTERN, txt, 0, 0);
      send_request(CMD_GET, txt, 0, pick_id());
    end
    write_base(32'hFFFFFFFF);
    send_request(CMD_GET, txt, 0, 32'hFFFFFFFF);
    send_request(CMD_GET, txt, 0, 32'h0);

    write_base(32'h0);
    for (int k = 0; k < 10; k++) send_request(CMD_GET, txt, 0, pick_id());

    start_i <= 1'b0;
    settle();
    $display("covered %0d result beats, %0d strings added, %0d records, %0d arena bytes",
             beats_checked, strings_added, rec_cnt, arena_fill);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("string_interning_table_unit: match");
    end else begin
      $display("%0d beats still expected", answer_q.size());
      $display("string_interning_table_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sit_pkg.sv
rtl/sit_ram.sv
rtl/sit_datapath.sv
rtl/sit_ctrl.sv
rtl/string_interning_table_unit.sv
tb/tb.sv
